/* hw/rtl/upe_pkg.sv */
// ----------------------------------------------------------------------------
// upe_pkg
// Types, constants and helpers shared by the URI percent-encoder blocks.
// ----------------------------------------------------------------------------
package upe_pkg;

  localparam logic [7:0] ESCAPE_CHAR  = 8'h25;  // '%'
  localparam logic [7:0] TABLE_BASE   = 8'd32;
  localparam logic [7:0] TABLE_LIMIT  = 8'd128;
  localparam logic [3:0] MASK_RESET   = 4'hF;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       final_byte;
  } upe_in_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       run_last;
    logic       text_end;
  } upe_out_t;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    logic [7:0] code;
    logic       escape;
    logic       final_byte;
  } upe_entry_t;

  // Class bits for codes 32..127.
  localparam logic [3:0] CLASS_TABLE [0:95] = '{
    4'h0,4'h0,4'h0,4'h0,4'h0,4'h0,4'h0,4'h0,4'h0,4'h0,4'hF,4'hE,4'h0,4'hF,4'hF,4'hC,
    4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'h8,4'h0,4'h0,4'h0,4'h0,4'h0,
    4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,
    4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'h0,4'h0,4'h0,4'h0,4'hF,
    4'h0,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,
    4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'hF,4'h0,4'h0,4'h0,4'h0,4'h0
  };

  // Upper-case hex digit for one nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] d;
    if (nib < 4'd10) begin
      d = 8'h30 + {4'h0, nib};
    end else begin
      d = 8'h37 + {4'h0, nib};
    end
    return d;
  endfunction

endpackage

/* hw/rtl/upe_front.sv */
// ----------------------------------------------------------------------------
// upe_front
// Input stage: accepts text bytes, looks up the class table and registers
// each byte with its escape decision.
// ----------------------------------------------------------------------------
module upe_front
  import upe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [3:0] class_mask,
  input  logic       in_valid,
  output logic       in_ready,
  input  upe_in_t    in_data,
  output logic       ent_valid,
  input  logic       ent_ready,
  output upe_entry_t ent_data
);

  logic       valid_r;
  logic       valid_nxt;
  upe_entry_t ent_r;
  upe_entry_t ent_nxt;
  logic       in_table;
  logic [6:0] tbl_idx;
  logic       passes;

  assign in_table = (in_data.byte_in >= TABLE_BASE) && (in_data.byte_in < TABLE_LIMIT);
  assign tbl_idx  = in_data.byte_in[6:0] - TABLE_BASE[6:0];
  assign passes   = in_table && ((CLASS_TABLE[tbl_idx] & class_mask) != 4'h0);

  assign in_ready = !valid_r || ent_ready;

  always_comb begin
    valid_nxt = valid_r;
    ent_nxt   = ent_r;
    if (in_ready) begin
      valid_nxt          = in_valid;
      ent_nxt.code       = in_data.byte_in;
      ent_nxt.escape     = !passes;
      ent_nxt.final_byte = in_data.final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent_valid = valid_r;
  assign ent_data  = ent_r;

endmodule

/* hw/rtl/upe_queue.sv */
// ----------------------------------------------------------------------------
// upe_queue
// Small flop-based FIFO of classified bytes between front and back end.
// ----------------------------------------------------------------------------
module upe_queue
  import upe_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_valid,
  output logic       wr_ready,
  input  upe_entry_t wr_data,
  output logic       rd_valid,
  input  logic       rd_ready,
  output upe_entry_t rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  upe_entry_t    mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r;
  logic [PW-1:0] rd_ptr_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          push;
  logic          pop;

  assign wr_ready = (count_r != FULL_CNT);
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* hw/rtl/upe_back.sv */
// ----------------------------------------------------------------------------
// upe_back
// Output stage: expands each queued byte into one passed beat or the
// three-beat escape '%', high digit, low digit, into an output register.
// ----------------------------------------------------------------------------
module upe_back
  import upe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       ent_valid,
  output logic       ent_ready,
  input  upe_entry_t ent_data,
  output logic       out_valid,
  input  logic       out_ready,
  output upe_out_t   out_data
);

  localparam logic [1:0] PH_PCT = 2'd0;
  localparam logic [1:0] PH_HI  = 2'd1;
  localparam logic [1:0] PH_LO  = 2'd2;

  logic       out_valid_r;
  logic       out_valid_nxt;
  upe_out_t   out_data_r;
  upe_out_t   out_data_nxt;
  logic [1:0] phase_r;
  logic [1:0] phase_nxt;
  logic       load;
  upe_out_t   beat;
  logic       beat_last;

  assign load = ent_valid && (!out_valid_r || out_ready);

  always_comb begin
    beat      = '0;
    beat_last = 1'b1;
    if (!ent_data.escape) begin
      beat.byte_out = ent_data.code;
    end else begin
      case (phase_r)
        PH_PCT: begin
          beat.byte_out = ESCAPE_CHAR;
          beat_last     = 1'b0;
        end
        PH_HI: begin
          beat.byte_out = hex_digit(ent_data.code[7:4]);
          beat_last     = 1'b0;
        end
        default: begin
          beat.byte_out = hex_digit(ent_data.code[3:0]);
        end
      endcase
    end
    beat.run_last = beat_last;
    beat.text_end = beat_last && ent_data.final_byte;
  end

  // Pop the queue on the last beat of a byte.
  assign ent_ready = load && beat_last;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    phase_nxt     = phase_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = beat;
      case (phase_r)
        PH_PCT:  phase_nxt = beat_last ? PH_PCT : PH_HI;
        PH_HI:   phase_nxt = PH_LO;
        default: phase_nxt = PH_PCT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= PH_PCT;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hw/rtl/uri_percent_encoder_core.sv */
// ----------------------------------------------------------------------------
// uri_percent_encoder_core
// URI percent-escaping of a byte stream, one text byte per input beat.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------
//   in_     | input     | in_valid/in_ready   | upe_in_t  (byte, final)
//   out_    | output    | out_valid/out_ready | upe_out_t (byte, last, end)
//   cfg_    | input     | cfg_wr_en           | class mask, 4 bits
//
// A passed byte takes one output beat, an escaped byte three; the output port
// at one beat per cycle while out_ready is high sets the sustained rate. An
// input beat passes the input register, the queue and the output register.
// Reset is synchronous, active low; the mask resets to 0xF. The queue lets
// the input keep flowing while the output expands or stalls.
// ----------------------------------------------------------------------------
module uri_percent_encoder_core
  import upe_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  upe_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output upe_out_t   out_data,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data
);

  logic [3:0] class_mask_r;
  logic [3:0] class_mask_nxt;
  logic       fq_valid;
  logic       fq_ready;
  upe_entry_t fq_data;
  logic       qb_valid;
  logic       qb_ready;
  upe_entry_t qb_data;

  assign class_mask_nxt = cfg_wr_en ? cfg_wr_data : class_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_mask_r <= MASK_RESET;
    end else begin
      class_mask_r <= class_mask_nxt;
    end
  end

  upe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .class_mask (class_mask_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .ent_valid  (fq_valid),
    .ent_ready  (fq_ready),
    .ent_data   (fq_data)
  );

  upe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  upe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ent_valid (qb_valid),
    .ent_ready (qb_ready),
    .ent_data  (qb_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
